// ===== design/rqk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqk_pkg
// Shared codes and controller/datapath interface types for the ready queue.
// ----------------------------------------------------------------------------
package rqk_pkg;

    // request codes
    localparam logic [2:0] ACT_PUSH   = 3'd0;
    localparam logic [2:0] ACT_POP    = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_ROTATE = 3'd3;
    localparam logic [2:0] ACT_LOOKUP = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture id, clear result and scan state
        logic push;        // append id at the tail (or flag full)
        logic take_pop;    // head data -> result, drop head
        logic take_rot;    // head data -> result, copy to tail, advance head
        logic set_ok;      // mark lookup success
        logic search;      // run id search scan
        logic shift_init;  // start closing the gap after the found entry
        logic shift;       // run gap-closing scan
        logic shift_fin;   // remove done: shrink queue
        logic summ;        // run summary scan (head, tail, largest id)
        logic scan_clear;  // restart scan from the head
        logic out_load;    // load result registers
    } rqk_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic hit;
        logic exhausted;   // scan has no reads left and nothing in flight
    } rqk_stat_t;

endpackage

// ===== design/rqk_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqk_ctrl
// Request sequencer: steps each item through its phases and runs the
// output handshake.
// ----------------------------------------------------------------------------
module rqk_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        action,
    output logic              out_valid,
    input  logic              out_ready,
    input  rqk_pkg::rqk_stat_t st,
    output rqk_pkg::rqk_cmd_t  cmd
);
    import rqk_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_TAKE_WAIT,
        S_TAKE,
        S_SEARCH,
        S_SHIFT,
        S_SUMMARY,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    op_next  = action;
                    case (action)
                        ACT_PUSH:   state_next = S_PUSH;
                        ACT_POP:    state_next = S_TAKE_WAIT;
                        ACT_ROTATE: state_next = S_TAKE_WAIT;
                        ACT_REMOVE: state_next = S_SEARCH;
                        ACT_LOOKUP: state_next = S_SEARCH;
                        default:    state_next = S_SUMMARY;  // ignored request
                    endcase
                end
            end
            S_PUSH:
            begin
                cmd.push       = 1'b1;
                cmd.scan_clear = 1'b1;
                state_next     = S_SUMMARY;
            end
            S_TAKE_WAIT:
            begin
                // head entry is being read this cycle
                if (st.empty)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SUMMARY;
                end
                else
                begin
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                if (op_reg == ACT_POP)
                begin
                    cmd.take_pop = 1'b1;
                end
                else
                begin
                    cmd.take_rot = 1'b1;
                end
                cmd.scan_clear = 1'b1;
                state_next     = S_SUMMARY;
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                if (st.hit)
                begin
                    if (op_reg == ACT_REMOVE)
                    begin
                        cmd.shift_init = 1'b1;
                        state_next     = S_SHIFT;
                    end
                    else
                    begin
                        cmd.set_ok     = 1'b1;
                        cmd.scan_clear = 1'b1;
                        state_next     = S_SUMMARY;
                    end
                end
                else if (st.exhausted)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SUMMARY;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (st.exhausted)
                begin
                    cmd.shift_fin  = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SUMMARY;
                end
            end
            S_SUMMARY:
            begin
                cmd.summ = 1'b1;
                if (st.exhausted)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= ACT_PUSH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/rqk_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqk_dpath
// Id store (circular buffer with one read and one write port), scan
// pipeline, search/compare, summary accumulation and result registers.
// ----------------------------------------------------------------------------
module rqk_dpath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rqk_pkg::rqk_cmd_t                   cmd,
    input  logic [ID_BITS-1:0]                  thread_id,
    output rqk_pkg::rqk_stat_t                  st,
    output logic [1:0]                          status,
    output logic [ID_BITS-1:0]                  result_id,
    output logic [ID_BITS-1:0]                  head_id,
    output logic [ID_BITS-1:0]                  tail_id,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    queue_length,
    output logic signed [ID_BITS:0]             top_id
);
    import rqk_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    // base + off with base below the depth and off at most the depth, wrapped into the buffer
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(QUEUE_DEPTH))
        begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [ID_BITS-1:0] entry_ids [QUEUE_DEPTH];

    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               s1_valid_reg, s1_valid_next;
    logic [CW-1:0]      s1_idx_reg, s1_idx_next;
    logic               hit_reg, hit_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [ID_BITS-1:0] key_reg, key_next;
    logic [ID_BITS-1:0] res_reg, res_next;
    logic [1:0]         code_reg, code_next;
    logic [ID_BITS-1:0] head_s_reg, head_s_next;
    logic [ID_BITS-1:0] tail_s_reg, tail_s_next;
    logic [ID_BITS-1:0] top_reg, top_next;
    logic               top_any_reg, top_any_next;
    logic [ID_BITS-1:0] rd_data_reg;

    logic [1:0]                 status_reg, status_next;
    logic [ID_BITS-1:0]         result_reg, result_next;
    logic [ID_BITS-1:0]         head_out_reg, head_out_next;
    logic [ID_BITS-1:0]         tail_out_reg, tail_out_next;
    logic [CW-1:0]              len_out_reg, len_out_next;
    logic [ID_BITS:0]           top_out_reg, top_out_next;

    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      tail_addr;
    logic [AW-1:0]      head_inc;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ID_BITS-1:0] wr_data;
    logic               can_read;
    logic               full;

    assign rd_addr   = wrap_add(head_reg, idx_reg);
    assign tail_addr = wrap_add(head_reg, count_reg);
    assign head_inc  = wrap_add(head_reg, CW'(1));
    assign can_read  = (idx_reg < count_reg);
    assign full      = (count_reg == CW'(QUEUE_DEPTH));

    assign st.empty     = (count_reg == '0);
    assign st.hit       = hit_reg;
    assign st.exhausted = !can_read && !s1_valid_reg;

    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        s1_valid_next = s1_valid_reg;
        s1_idx_next   = s1_idx_reg;
        hit_next      = hit_reg;
        pos_next      = pos_reg;
        key_next      = key_reg;
        res_next      = res_reg;
        code_next     = code_reg;
        head_s_next   = head_s_reg;
        tail_s_next   = tail_s_reg;
        top_next      = top_reg;
        top_any_next  = top_any_reg;
        status_next   = status_reg;
        result_next   = result_reg;
        head_out_next = head_out_reg;
        tail_out_next = tail_out_reg;
        len_out_next  = len_out_reg;
        top_out_next  = top_out_reg;
        wr_en         = 1'b0;
        wr_addr       = tail_addr;
        wr_data       = key_reg;

        if (cmd.load)
        begin
            key_next      = thread_id;
            res_next      = '0;
            code_next     = ST_MISS;
            idx_next      = '0;
            s1_valid_next = 1'b0;
            hit_next      = 1'b0;
            top_any_next  = 1'b0;
        end

        if (cmd.push)
        begin
            if (full)
            begin
                code_next = ST_FULL;
            end
            else
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                res_next   = key_reg;
                code_next  = ST_OK;
            end
        end

        if (cmd.take_pop)
        begin
            res_next   = rd_data_reg;
            head_next  = head_inc;
            count_next = count_reg - CW'(1);
            code_next  = ST_OK;
        end

        if (cmd.take_rot)
        begin
            // on a full queue the tail slot is the head slot: same value back
            wr_en     = 1'b1;
            wr_data   = rd_data_reg;
            res_next  = rd_data_reg;
            head_next = head_inc;
            code_next = ST_OK;
        end

        if (cmd.set_ok)
        begin
            code_next = ST_OK;
        end

        if (cmd.shift_fin)
        begin
            count_next = count_reg - CW'(1);
            code_next  = ST_OK;
        end

        // scan pipeline: read issued at idx, data arrives in the next cycle with s1_idx
        if (cmd.search || cmd.shift || cmd.summ)
        begin
            if (can_read && !(cmd.search && hit_reg))
            begin
                idx_next      = idx_reg + CW'(1);
                s1_valid_next = 1'b1;
                s1_idx_next   = idx_reg;
            end
            else
            begin
                s1_valid_next = 1'b0;
            end
        end

        if (cmd.search && s1_valid_reg && !hit_reg && (rd_data_reg == key_reg))
        begin
            hit_next = 1'b1;
            pos_next = s1_idx_reg;
            res_next = rd_data_reg;
        end

        if (cmd.shift && s1_valid_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = wrap_add(head_reg, CW'(s1_idx_reg - CW'(1)));
            wr_data = rd_data_reg;
        end

        if (cmd.summ && s1_valid_reg)
        begin
            if (s1_idx_reg == '0)
            begin
                head_s_next = rd_data_reg;
            end
            if (s1_idx_reg == CW'(count_reg - CW'(1)))
            begin
                tail_s_next = rd_data_reg;
            end
            if (!top_any_reg || (rd_data_reg > top_reg))
            begin
                top_next     = rd_data_reg;
                top_any_next = 1'b1;
            end
        end

        if (cmd.scan_clear)
        begin
            idx_next      = '0;
            s1_valid_next = 1'b0;
            top_any_next  = 1'b0;
        end

        if (cmd.shift_init)
        begin
            idx_next      = pos_reg + CW'(1);
            s1_valid_next = 1'b0;
        end

        if (cmd.out_load)
        begin
            status_next   = code_reg;
            result_next   = res_reg;
            head_out_next = (count_reg == '0) ? '0 : head_s_reg;
            tail_out_next = (count_reg == '0) ? '0 : tail_s_reg;
            len_out_next  = count_reg;
            top_out_next  = top_any_reg ? {1'b0, top_reg} : '1;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= entry_ids[rd_addr];
        if (wr_en)
        begin
            entry_ids[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            top_any_reg  <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            s1_valid_reg <= s1_valid_next;
            hit_reg      <= hit_next;
            top_any_reg  <= top_any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= s1_idx_next;
        pos_reg      <= pos_next;
        key_reg      <= key_next;
        res_reg      <= res_next;
        code_reg     <= code_next;
        head_s_reg   <= head_s_next;
        tail_s_reg   <= tail_s_next;
        top_reg      <= top_next;
        status_reg   <= status_next;
        result_reg   <= result_next;
        head_out_reg <= head_out_next;
        tail_out_reg <= tail_out_next;
        len_out_reg  <= len_out_next;
        top_out_reg  <= top_out_next;
    end

    assign status       = status_reg;
    assign result_id    = result_reg;
    assign head_id      = head_out_reg;
    assign tail_id      = tail_out_reg;
    assign queue_length = len_out_reg;
    assign top_id       = signed'(top_out_reg);

endmodule

// ===== design/ready_queue_with_keyed_removal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ready_queue_with_keyed_removal
// Ordered ready queue of thread ids: push, pop, remove by id, rotate, lookup.
// ----------------------------------------------------------------------------
// One item at a time. Each item ends with a summary scan that walks the
// queue (n entries after the step) to find head, tail and the largest id.
// Lookup searches first; remove searches and then closes the gap. All of
// these walks go through the single read port of the id memory, one
// entry per cycle. A new item is taken while the previous result is still
// waiting on the output; the block stalls before loading the next result.
// No clearing pass after reset: stored ids are only read inside the
// current length.
module ready_queue_with_keyed_removal #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [2:0]                          action,
    input  logic [ID_BITS-1:0]                  thread_id,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic [ID_BITS-1:0]                  result_id,
    output logic [ID_BITS-1:0]                  head_id,
    output logic [ID_BITS-1:0]                  tail_id,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    queue_length,
    output logic signed [ID_BITS:0]             top_id
);
    import rqk_pkg::*;

    rqk_cmd_t  cmd;
    rqk_stat_t st;

    rqk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    rqk_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .thread_id    (thread_id),
        .st           (st),
        .status       (status),
        .result_id    (result_id),
        .head_id      (head_id),
        .tail_id      (tail_id),
        .queue_length (queue_length),
        .top_id       (top_id)
    );

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in progress");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (queue_length <= QUEUE_DEPTH))
        else $error("queue length beyond depth");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |-> (queue_length == QUEUE_DEPTH))
        else $error("push dropped on a queue that is not full");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (result_id == '0))
        else $error("non-zero result id on a failed request");

    a_empty_view: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (queue_length == '0)) |->
            ((head_id == '0) && (tail_id == '0) && (top_id == {(ID_BITS+1){1'b1}})))
        else $error("empty queue reported with entries");
`endif

endmodule
